### sv/char_lcd_nibble_write_sequencer_macros.svh
// Assertion macros shared by the checker of the display write sequencer.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CLNWS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("display write sequencer check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CLNWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("display write sequencer check failed");

`endif

### sv/clnws_pkg.sv
// Types, codes and helpers shared by the display write sequencer modules.
`timescale 1ns / 1ps

package clnws_pkg;

   localparam int QUEUE_DEPTH_DEF = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int TICK_W = 8;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_CURSOR = 2'd2;

   localparam logic CSR_IDX_HIGH = 1'b0;
   localparam logic CSR_IDX_LOW = 1'b1;

   localparam logic [TICK_W-1:0] HIGH_TICKS_RST = 8'd1;
   localparam logic [TICK_W-1:0] LOW_TICKS_RST = 8'd2;

   localparam logic [7:0] ROW0_BASE = 8'h80;
   localparam logic [7:0] ROW1_BASE = 8'hC0;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] byte_value;
      logic       is_character;
      logic       cursor_row;
      logic [5:0] cursor_col;
   } req_type;

   typedef struct packed {
      logic       select_pin;
      logic       enable_pin;
      logic [3:0] bus_nibble;
      logic       busy_res;
      logic       rejected;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_TICK,
      CMD_SEND
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic         select;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_head_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HI_EN,
      PH_HI_GAP,
      PH_LO_EN,
      PH_LO_GAP
   } phase_type;

   // A programmed count of zero behaves as a single tick.
   function automatic logic [TICK_W-1:0] ticks_of(input logic [TICK_W-1:0] v);
      return (v == '0) ? TICK_W'(1) : v;
   endfunction

endpackage

### sv/clnws_front.sv
// Request decoder and command queue of the display write sequencer.
`timescale 1ns / 1ps

module clnws_front import clnws_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_type      req_data,
   output cmd_head_type head,
   input  logic         deq
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   cmd_type            slot_ff [QUEUE_DEPTH];
   cmd_type            cmd_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               enq;

   always_comb begin
      cmd_in.kind = CMD_NONE;
      cmd_in.data = req_data.byte_value;
      cmd_in.select = req_data.is_character;
      case (req_data.op)
         OP_TICK: begin
            cmd_in.kind = CMD_TICK;
         end
         OP_WRITE: begin
            cmd_in.kind = CMD_SEND;
         end
         OP_CURSOR: begin
            cmd_in.kind = CMD_SEND;
            cmd_in.data = (req_data.cursor_row ? ROW1_BASE : ROW0_BASE)
                          + {2'b00, req_data.cursor_col};
            cmd_in.select = 1'b0;
         end
         default: begin
            cmd_in.kind = CMD_NONE;
         end
      endcase
   end

   assign full = (count_ff == DEPTH_CNT);
   assign enq = push && !full;
   assign head.valid = (count_ff != '0);
   assign head.cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (enq) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(enq) - CNT_W'(deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         slot_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

### sv/clnws_back.sv
// Nibble write sequencer and result register of the display write sequencer.
`timescale 1ns / 1ps

module clnws_back import clnws_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [TICK_W-1:0]  high_ticks,
   input  logic [TICK_W-1:0]  low_ticks,
   input  cmd_head_type       head,
   output logic               deq,
   output logic               empty,
   input  logic               pop,
   output rsp_type            rsp_data
);

   phase_type          phase_ff, phase_in;
   logic [TICK_W-1:0]  ticks_ff, ticks_in;
   logic [7:0]         byte_ff, byte_in;
   logic               select_ff, select_in;
   logic               enable_ff, enable_in;
   logic [3:0]         nibble_ff, nibble_in;
   rsp_type            out_ff, out_in;
   logic               out_valid_ff, out_valid_in;
   logic               step;
   logic               rejected;

   assign step = head.valid && (!out_valid_ff || pop);
   assign deq = step;
   assign empty = !out_valid_ff;
   assign rsp_data = out_ff;

   always_comb begin
      phase_in = phase_ff;
      ticks_in = ticks_ff;
      byte_in = byte_ff;
      select_in = select_ff;
      enable_in = enable_ff;
      nibble_in = nibble_ff;
      rejected = 1'b0;
      if (step) begin
         case (head.cmd.kind)
            CMD_SEND: begin
               if (phase_ff != PH_IDLE) begin
                  rejected = 1'b1;
               end else begin
                  byte_in = head.cmd.data;
                  select_in = head.cmd.select;
                  nibble_in = head.cmd.data[7:4];
                  enable_in = 1'b1;
                  ticks_in = ticks_of(high_ticks);
                  phase_in = PH_HI_EN;
               end
            end
            CMD_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  if (ticks_ff > TICK_W'(1)) begin
                     ticks_in = ticks_ff - TICK_W'(1);
                  end else begin
                     case (phase_ff)
                        PH_HI_EN: begin
                           enable_in = 1'b0;
                           ticks_in = ticks_of(low_ticks);
                           phase_in = PH_HI_GAP;
                        end
                        PH_HI_GAP: begin
                           nibble_in = byte_ff[3:0];
                           enable_in = 1'b1;
                           ticks_in = ticks_of(high_ticks);
                           phase_in = PH_LO_EN;
                        end
                        PH_LO_EN: begin
                           enable_in = 1'b0;
                           ticks_in = ticks_of(low_ticks);
                           phase_in = PH_LO_GAP;
                        end
                        default: begin
                           enable_in = 1'b0;
                           ticks_in = '0;
                           phase_in = PH_IDLE;
                        end
                     endcase
                  end
               end
            end
            default: begin
               rejected = 1'b0;
            end
         endcase
      end
      out_in.select_pin = select_in;
      out_in.enable_pin = enable_in;
      out_in.bus_nibble = nibble_in;
      out_in.busy_res = (phase_in != PH_IDLE);
      out_in.rejected = rejected;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         ticks_ff <= '0;
         byte_ff <= '0;
         select_ff <= 1'b0;
         enable_ff <= 1'b0;
         nibble_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
         byte_ff <= byte_in;
         select_ff <= select_in;
         enable_ff <= enable_in;
         nibble_ff <= nibble_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= out_in;
      end
   end

endmodule

### sv/char_lcd_nibble_write_sequencer.sv
// Top level of the 4-bit character display write sequencer with its register port.
`timescale 1ns / 1ps

// Each request (a tick, a byte write or a cursor move) yields exactly one result
// that shows the select, enable and data pin levels after the request, whether a
// transfer is running, and whether the request was dropped for arriving while
// busy. One request is taken per clock cycle while the queue is not full; its
// result reaches the result ports through the command queue and then the result
// register when the result side keeps up, the request waiting at the head of the
// command queue until the result register takes it. The queue depth sets how many requests can wait before
// full rises. The timing registers lie at byte addresses 0 (enable high ticks)
// and 4 (enable low ticks) and should only be written while no request is
// outstanding.
module char_lcd_nibble_write_sequencer import clnws_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  req_type                req_data,
   output logic                   empty,
   input  logic                   pop,
   output rsp_type                rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   logic [TICK_W-1:0]  high_ticks_ff, high_ticks_in;
   logic [TICK_W-1:0]  low_ticks_ff, low_ticks_in;
   logic               csr_write;
   logic               csr_index;
   cmd_head_type       head;
   logic               deq;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[2];

   always_comb begin
      high_ticks_in = high_ticks_ff;
      low_ticks_in = low_ticks_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_IDX_HIGH: begin
               high_ticks_in = pwdata[TICK_W-1:0];
            end
            CSR_IDX_LOW: begin
               low_ticks_in = pwdata[TICK_W-1:0];
            end
            default: begin
               high_ticks_in = high_ticks_ff;
            end
         endcase
      end
      prdata = (csr_index == CSR_IDX_LOW) ? CSR_DATA_W'(low_ticks_ff)
                                          : CSR_DATA_W'(high_ticks_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ticks_ff <= HIGH_TICKS_RST;
         low_ticks_ff <= LOW_TICKS_RST;
      end else begin
         high_ticks_ff <= high_ticks_in;
         low_ticks_ff <= low_ticks_in;
      end
   end

   clnws_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .head     (head),
      .deq      (deq)
   );

   clnws_back u_back (
      .clock      (clock),
      .reset      (reset),
      .high_ticks (high_ticks_ff),
      .low_ticks  (low_ticks_ff),
      .head       (head),
      .deq        (deq),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule

### sv/clnws_checker.sv
// Port-level checks of the display write sequencer and their binding.
`timescale 1ns / 1ps
`include "char_lcd_nibble_write_sequencer_macros.svh"

module clnws_checker import clnws_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_data
);

   `CLNWS_ASSERT_NOW(a_reject_only_when_busy, clock, reset, !empty && rsp_data.rejected, rsp_data.busy_res)
   `CLNWS_ASSERT_NOW(a_enable_low_when_idle, clock, reset, !empty && !rsp_data.busy_res, !rsp_data.enable_pin)
   `CLNWS_ASSERT_NEXT(a_result_holds, clock, reset, !empty && !pop, !empty && $stable(rsp_data))

endmodule

bind char_lcd_nibble_write_sequencer clnws_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);

### tb/char_lcd_pin_checker.sv
// Checker that predicts and compares the pin levels reported by the display write sequencer.
`timescale 1ns / 1ps

module char_lcd_pin_checker import clnws_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic                  full,
   input  req_type               req_data,
   input  logic                  empty,
   input  logic                  pop,
   input  rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic [CSR_DATA_W-1:0] prdata,
   input  logic                  pready,
   output int                    fail_count,
   output int                    outstanding
);

   logic [7:0] high_ticks;
   logic [7:0] low_ticks;
   phase_type  phase;
   logic [7:0] ticks_left;
   logic [7:0] latched_byte;
   logic       select_level;
   logic       enable_level;
   logic [3:0] nibble_out;
   rsp_type    pins_due[$];
   int         reports;

   initial begin
      fail_count = 0;
      outstanding = 0;
      reports = 0;
   end

   function automatic logic [7:0] at_least_one(input logic [7:0] v);
      return (v == 8'd0) ? 8'd1 : v;
   endfunction

   task automatic load_byte(input logic [7:0] b, input logic sel);
      latched_byte = b;
      select_level = sel;
      nibble_out = b[7:4];
      enable_level = 1'b1;
      ticks_left = at_least_one(high_ticks);
      phase = PH_HI_EN;
   endtask

   task automatic advance_tick();
      if (phase != PH_IDLE) begin
         if (ticks_left > 8'd1) begin
            ticks_left = ticks_left - 8'd1;
         end else begin
            case (phase)
               PH_HI_EN: begin
                  enable_level = 1'b0;
                  ticks_left = at_least_one(low_ticks);
                  phase = PH_HI_GAP;
               end
               PH_HI_GAP: begin
                  nibble_out = latched_byte[3:0];
                  enable_level = 1'b1;
                  ticks_left = at_least_one(high_ticks);
                  phase = PH_LO_EN;
               end
               PH_LO_EN: begin
                  enable_level = 1'b0;
                  ticks_left = at_least_one(low_ticks);
                  phase = PH_LO_GAP;
               end
               default: begin
                  enable_level = 1'b0;
                  ticks_left = 8'd0;
                  phase = PH_IDLE;
               end
            endcase
         end
      end
   endtask

   task automatic predict_pins(input req_type r, output rsp_type o);
      logic dropped;
      dropped = 1'b0;
      case (r.op)
         OP_TICK: advance_tick();
         OP_WRITE, OP_CURSOR: begin
            if (phase != PH_IDLE) begin
               dropped = 1'b1;
            end else if (r.op == OP_WRITE) begin
               load_byte(r.byte_value, r.is_character);
            end else begin
               load_byte((r.cursor_row ? ROW1_BASE : ROW0_BASE) + {2'b00, r.cursor_col}, 1'b0);
            end
         end
         default: ;
      endcase
      o.select_pin = select_level;
      o.enable_pin = enable_level;
      o.bus_nibble = nibble_out;
      o.busy_res = (phase != PH_IDLE);
      o.rejected = dropped;
   endtask

   task automatic note_failure(input string what);
      fail_count++;
      if (reports < 10) begin
         $display("%0t: %s", $realtime, what);
      end
      reports++;
   endtask

   always @(posedge clock) begin : watch
      rsp_type    want;
      rsp_type    got;
      logic [7:0] stored;
      if (reset) begin
         high_ticks = HIGH_TICKS_RST;
         low_ticks = LOW_TICKS_RST;
         phase = PH_IDLE;
         ticks_left = 8'd0;
         latched_byte = 8'd0;
         select_level = 1'b0;
         enable_level = 1'b0;
         nibble_out = 4'd0;
         pins_due.delete();
      end else begin
         if (pop && !empty) begin
            got = rsp_data;
            if (pins_due.size() == 0) begin
               note_failure($sformatf("Unexpected result sel %b en %b bus %h busy %b rej %b",
                  got.select_pin, got.enable_pin, got.bus_nibble, got.busy_res, got.rejected));
            end else begin
               want = pins_due.pop_front();
               if (got.select_pin !== want.select_pin || got.enable_pin !== want.enable_pin ||
                   got.bus_nibble !== want.bus_nibble || got.busy_res !== want.busy_res ||
                   got.rejected !== want.rejected) begin
                  note_failure($sformatf(
                     "Mismatch: expected sel %b en %b bus %h busy %b rej %b, got sel %b en %b bus %h busy %b rej %b",
                     want.select_pin, want.enable_pin, want.bus_nibble, want.busy_res,
                     want.rejected, got.select_pin, got.enable_pin, got.bus_nibble,
                     got.busy_res, got.rejected));
               end
            end
         end
         if (push && !full) begin
            predict_pins(req_data, want);
            pins_due.push_back(want);
         end
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr[2] == CSR_IDX_HIGH) begin
                  high_ticks = pwdata[7:0];
               end else begin
                  low_ticks = pwdata[7:0];
               end
            end else begin
               stored = (paddr[2] == CSR_IDX_HIGH) ? high_ticks : low_ticks;
               if (prdata !== {{(CSR_DATA_W-8){1'b0}}, stored}) begin
                  note_failure($sformatf("Register read at %h: expected %h, got %h",
                     paddr, stored, prdata));
               end
            end
         end
      end
      outstanding = pins_due.size();
   end

endmodule

### tb/char_lcd_nibble_write_sequencer_test.sv
// Testbench top for the display write sequencer: request stimulus, timing setup and verdict.
`timescale 1ns / 1ps

module char_lcd_nibble_write_sequencer_test;
   import clnws_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ADDR_HIGH_TICKS = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_LOW_TICKS = 3'd4;

   logic                  clock;
   logic                  reset;
   logic                  push;
   logic                  full;
   req_type               req_data;
   logic                  empty;
   logic                  pop;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    fail_count;
   int                    outstanding;
   int                    cycles;
   logic [7:0]            high_ticks;
   logic [7:0]            low_ticks;
   int                    busy_left;
   bit                    sender_idles;
   bit                    receiver_idles;
   int                    n_ticks;
   int                    n_writes;
   int                    n_cursor;
   int                    n_unused;
   int                    n_settings;
   int                    n_pauses;

   char_lcd_nibble_write_sequencer uut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   char_lcd_pin_checker pin_check (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : result_side
      int stall;
      stall = 0;
      pop <= 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            pop <= 1'b0;
            stall--;
         end else if (receiver_idles && $urandom_range(0, 11) == 0) begin
            pop <= 1'b0;
            stall = $urandom_range(0, 9);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   function automatic req_type make_req(input logic [1:0] op, input logic [7:0] b,
                                        input logic ch, input logic row, input logic [5:0] col);
      req_type r;
      r.op = op;
      r.byte_value = b;
      r.is_character = ch;
      r.cursor_row = row;
      r.cursor_col = col;
      return r;
   endfunction

   function automatic req_type random_fields(input logic [1:0] op);
      int         pick;
      logic [7:0] b;
      logic [5:0] col;
      pick = $urandom_range(0, 15);
      b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 9);
      col = (pick == 0) ? 6'd0 : (pick == 1) ? 6'd63 : 6'($urandom_range(0, 63));
      return make_req(op, b, 1'($urandom), 1'($urandom), col);
   endfunction

   function automatic req_type random_item();
      int         pick;
      logic [1:0] op;
      pick = $urandom_range(0, 99);
      if (busy_left == 0) begin
         op = (pick < 30) ? OP_WRITE : (pick < 50) ? OP_CURSOR : (pick < 56) ? OP_UNUSED : OP_TICK;
      end else begin
         op = (pick < 78) ? OP_TICK : (pick < 86) ? OP_WRITE : (pick < 93) ? OP_CURSOR : OP_UNUSED;
      end
      return random_fields(op);
   endfunction

   task automatic send_request(input req_type r);
      bit taken;
      if (sender_idles && $urandom_range(0, 9) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_data <= r;
      push <= 1'b1;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !full;
         @(posedge clock);
      end
      case (r.op)
         OP_TICK: begin
            n_ticks++;
            if (busy_left > 0) begin
               busy_left--;
            end
         end
         OP_WRITE, OP_CURSOR: begin
            if (r.op == OP_WRITE) begin
               n_writes++;
            end else begin
               n_cursor++;
            end
            if (busy_left == 0) begin
               busy_left = 2 * ((high_ticks == 8'd0 ? 1 : int'(high_ticks)) +
                                (low_ticks == 8'd0 ? 1 : int'(low_ticks)));
            end
         end
         default: n_unused++;
      endcase
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   task automatic finish_transfer();
      while (busy_left > 0) begin
         send_request(random_fields(OP_TICK));
      end
   endtask

   task automatic csr_access(input bit wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [7:0] v);
      bit ready;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= {24'($urandom), v};
      @(posedge clock);
      penable <= 1'b1;
      ready = 1'b0;
      while (!ready) begin
         @(negedge clock);
         ready = pready;
         @(posedge clock);
      end
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic program_timing(input logic [7:0] hi, input logic [7:0] lo);
      finish_transfer();
      wait_drained();
      csr_access(1'b1, ADDR_HIGH_TICKS, hi);
      csr_access(1'b1, ADDR_LOW_TICKS, lo);
      high_ticks = hi;
      low_ticks = lo;
      csr_access(1'b0, ADDR_HIGH_TICKS, 8'd0);
      csr_access(1'b0, ADDR_LOW_TICKS, 8'd0);
      n_settings++;
   endtask

   task automatic run_random(input int count);
      repeat (count) begin
         if (sender_idles && $urandom_range(0, 79) == 0) begin
            wait_drained();
            n_pauses++;
         end
         send_request(random_item());
      end
   endtask

   initial begin
      reset <= 1'b1;
      push <= 1'b0;
      req_data <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      high_ticks = HIGH_TICKS_RST;
      low_ticks = LOW_TICKS_RST;
      busy_left = 0;
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset timing: a write and a cursor move land while busy and are dropped; unused codes change nothing.
      send_request(make_req(OP_TICK, 8'h3C, 1'b1, 1'b0, 6'h2A));
      send_request(make_req(OP_UNUSED, 8'hFF, 1'b1, 1'b1, 6'h3F));
      send_request(make_req(OP_WRITE, 8'hA5, 1'b1, 1'b0, 6'h00));
      send_request(random_fields(OP_TICK));
      send_request(make_req(OP_WRITE, 8'hFF, 1'b0, 1'b1, 6'h3F));
      send_request(random_fields(OP_TICK));
      send_request(make_req(OP_CURSOR, 8'h00, 1'b1, 1'b1, 6'h05));
      send_request(make_req(OP_UNUSED, 8'h00, 1'b0, 1'b0, 6'h00));
      repeat (4) send_request(random_fields(OP_TICK));
      send_request(make_req(OP_WRITE, 8'hFF, 1'b1, 1'b1, 6'h3F));
      repeat (6) send_request(random_fields(OP_TICK));
      send_request(make_req(OP_CURSOR, 8'h00, 1'b0, 1'b1, 6'h3F));
      repeat (6) send_request(random_fields(OP_TICK));
      send_request(make_req(OP_CURSOR, 8'hFF, 1'b1, 1'b0, 6'h00));

      program_timing(8'd1, 8'd1);
      run_random(100);
      program_timing(8'd0, 8'd0);
      run_random(80);
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      program_timing(8'd3, 8'd2);
      run_random(100);
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      program_timing(8'd255, 8'd0);
      send_request(random_fields(OP_WRITE));
      run_random(8);
      program_timing(8'd0, 8'd255);
      send_request(random_fields(OP_CURSOR));
      run_random(8);
      program_timing(8'd5, 8'd3);
      run_random(80);
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      program_timing(8'd2, 8'd1);
      run_random(60);
      finish_transfer();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d requests: %0d ticks, %0d byte writes, %0d cursor moves, %0d unused codes.",
         n_ticks + n_writes + n_cursor + n_unused, n_ticks, n_writes, n_cursor, n_unused);
      $display("Ran under %0d timing settings from zero to 255 ticks, with %0d mid-run drains.",
         n_settings, n_pauses);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
